// File: rtl/lamv_pkg.sv
// Shared types, row codes and state encodings for the look-at view matrix unit.
`default_nettype none
package lamv_pkg;

    typedef logic [2:0][31:0] t_vec32;
    typedef logic [2:0][32:0] t_vec33;
    typedef logic [2:0][63:0] t_vec64;

    // One camera request after the front end: eye, up and (target - eye).
    typedef struct packed {
        t_vec32 eye;
        t_vec32 upv;
        t_vec33 dif;
    } t_item;

    // Normalizer status back to the sequencer.
    typedef struct packed {
        logic done;
        logic ok;
    } t_norm_rsp;

    localparam logic [1:0] ROW_SIDE = 2'd0;
    localparam logic [1:0] ROW_UP   = 2'd1;
    localparam logic [1:0] ROW_FWD  = 2'd2;

    localparam logic [31:0] AXIS_ONE = 32'h4000_0000;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_DIVLD,
        N_DIV,
        N_DONE
    } t_nstate;

    typedef enum logic [3:0] {
        B_IDLE,
        B_NF_GO,
        B_NF_WAIT,
        B_CR1,
        B_NS_GO,
        B_NS_WAIT,
        B_CR2,
        B_DOT,
        B_EMIT
    } t_bstate;

    function automatic logic [1:0] next3(input logic [1:0] k);
        logic [1:0] r;
        unique case (k)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] prev3(input logic [1:0] k);
        logic [1:0] r;
        unique case (k)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/lamv_front.sv
// Front end: takes a request transfer and forms the view direction.
`default_nettype none
module lamv_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_full,
    output logic                      o_push,
    output lamv_pkg::t_item           o_item,
    input  wire lamv_pkg::t_vec32     i_eye,
    input  wire lamv_pkg::t_vec32     i_tgt,
    input  wire lamv_pkg::t_vec32     i_upv
);

    logic            r_vld;
    lamv_pkg::t_item r_item;
    logic            w_take;

    assign o_stall = r_vld && i_full;
    assign o_push  = r_vld && !i_full;
    assign o_item  = r_item;
    assign w_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_take) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.eye <= i_eye;
            r_item.upv <= i_upv;
            for (int i = 0; i < 3; i++) begin
                r_item.dif[i] <= 33'($signed(i_tgt[i])) - 33'($signed(i_eye[i]));
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/lamv_fifo.sv
// Two-entry queue between the front end and the sequencer.
`default_nettype none
module lamv_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire lamv_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output lamv_pkg::t_item      o_item
);

    lamv_pkg::t_item r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule
`default_nettype wire

// File: rtl/lamv_norm.sv
// Vector normalizer: range shift, sum of squares, serial root, bit-serial divide.
`default_nettype none
module lamv_norm (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire lamv_pkg::t_vec64 i_vec,
    output lamv_pkg::t_norm_rsp   o_rsp,
    output lamv_pkg::t_vec32      o_axis
);

    lamv_pkg::t_nstate r_state, n_state;
    lamv_pkg::t_vec64  r_m;
    logic [2:0]        r_neg;
    logic [61:0]       r_sq;
    logic [63:0]       r_x;
    logic [63:0]       r_root;
    logic [63:0]       r_bit;
    logic [61:0]       r_num;
    logic [31:0]       r_rem;
    logic [31:0]       r_q;
    logic [5:0]        r_cnt;
    logic [1:0]        r_j;
    logic              r_ph;
    logic              r_ok;
    lamv_pkg::t_vec32  r_axis;

    logic [63:0] w_mx;
    logic [63:0] w_rb;
    logic        w_sq_ge;
    logic [32:0] w_trial;
    logic        w_qbit;
    logic [31:0] w_rem_n;
    logic [31:0] w_qn;
    logic [31:0] w_qc;

    always_comb begin
        w_mx = r_m[0];
        if (r_m[1] > w_mx) w_mx = r_m[1];
        if (r_m[2] > w_mx) w_mx = r_m[2];
        w_rb    = r_root + r_bit;
        w_sq_ge = (r_x >= w_rb);
        w_trial = {r_rem, r_num[61]};
        w_qbit  = (w_trial >= {1'b0, r_root[31:0]});
        w_rem_n = w_qbit ? 32'(w_trial - {1'b0, r_root[31:0]}) : w_trial[31:0];
        w_qn    = {r_q[30:0], w_qbit};
        w_qc    = (w_qn > lamv_pkg::AXIS_ONE) ? lamv_pkg::AXIS_ONE : w_qn;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lamv_pkg::N_IDLE:  if (i_start) n_state = lamv_pkg::N_SHIFT;
            lamv_pkg::N_SHIFT: begin
                if (w_mx == 64'd0) begin
                    n_state = lamv_pkg::N_DONE;
                end else if (w_mx[63:31] == 33'd0 && w_mx[30]) begin
                    n_state = lamv_pkg::N_SQ;
                end
            end
            lamv_pkg::N_SQ:    if (r_ph && r_j == 2'd2) n_state = lamv_pkg::N_SQRT;
            lamv_pkg::N_SQRT:  if (r_cnt == 6'd31) n_state = lamv_pkg::N_DIVLD;
            lamv_pkg::N_DIVLD: n_state = lamv_pkg::N_DIV;
            lamv_pkg::N_DIV: begin
                if (r_cnt == 6'd61) begin
                    n_state = (r_j == 2'd2) ? lamv_pkg::N_DONE : lamv_pkg::N_DIVLD;
                end
            end
            lamv_pkg::N_DONE:  n_state = lamv_pkg::N_IDLE;
            default:           n_state = lamv_pkg::N_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lamv_pkg::N_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            lamv_pkg::N_IDLE: begin
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= i_vec[i][63];
                    r_m[i]   <= i_vec[i][63] ? 64'd0 - i_vec[i] : i_vec[i];
                end
            end
            lamv_pkg::N_SHIFT: begin
                if (w_mx == 64'd0) begin
                    r_ok   <= 1'b0;
                    r_axis <= '0;
                end else if (w_mx[63:31] != 33'd0) begin
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                end else if (!w_mx[30]) begin
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                end else begin
                    r_ok <= 1'b1;
                    r_x  <= 64'd0;
                    r_j  <= 2'd0;
                    r_ph <= 1'b0;
                end
            end
            lamv_pkg::N_SQ: begin
                r_ph <= !r_ph;
                if (!r_ph) begin
                    r_sq <= r_m[r_j][30:0] * r_m[r_j][30:0];
                end else begin
                    r_x <= r_x + {2'd0, r_sq};
                    if (r_j == 2'd2) begin
                        r_root <= 64'd0;
                        r_bit  <= 64'h4000_0000_0000_0000;
                        r_cnt  <= 6'd0;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
            end
            lamv_pkg::N_SQRT: begin
                if (w_sq_ge) begin
                    r_x    <= r_x - w_rb;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 6'd1;
                r_j   <= 2'd0;
            end
            lamv_pkg::N_DIVLD: begin
                r_num <= {1'b0, r_m[r_j][30:0], 30'd0} + {31'd0, r_root[31:1]};
                r_rem <= 32'd0;
                r_q   <= 32'd0;
                r_cnt <= 6'd0;
            end
            lamv_pkg::N_DIV: begin
                r_rem <= w_rem_n;
                r_num <= r_num << 1;
                r_q   <= w_qn;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd61) begin
                    r_axis[r_j] <= r_neg[r_j] ? 32'd0 - w_qc : w_qc;
                    r_j         <= r_j + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.done = (r_state == lamv_pkg::N_DONE);
    assign o_rsp.ok   = r_ok;
    assign o_axis     = r_axis;

endmodule
`default_nettype wire

// File: rtl/lamv_back.sv
// Sequencer: runs normalize, cross and dot steps on a shared multiplier, then emits rows.
`default_nettype none
module lamv_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  wire lamv_pkg::t_item  i_item,
    output logic                  o_pop,
    output logic                  o_nstart,
    output lamv_pkg::t_vec64      o_nvec,
    input  wire lamv_pkg::t_norm_rsp i_nrsp,
    input  wire lamv_pkg::t_vec32 i_naxis,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [1:0]            o_row_index,
    output lamv_pkg::t_vec32      o_axis,
    output logic [31:0]           o_offset,
    output logic                  o_degenerate,
    output logic                  o_last_row
);

    lamv_pkg::t_bstate r_state, n_state;
    lamv_pkg::t_vec32  r_eye, r_upv, r_f, r_s, r_u;
    lamv_pkg::t_vec33  r_dif;
    lamv_pkg::t_vec64  r_c;
    lamv_pkg::t_vec32  r_off;
    logic              r_okf, r_oks;
    logic [1:0]        r_k, r_t;
    logic              r_ph;
    logic signed [63:0] r_prod;
    logic signed [65:0] r_acc;

    logic              r_ovld;
    logic [1:0]        r_orow;
    lamv_pkg::t_vec32  r_oaxis;
    logic [31:0]       r_ooff;
    logic              r_odeg;

    lamv_pkg::t_vec32  w_opa, w_opb;
    logic [1:0]        w_ia, w_ib;
    logic              w_minus, w_last_term;
    logic signed [65:0] w_term, w_acc_n;
    logic              w_load;

    function automatic logic [35:0] rnd30(input logic signed [65:0] v);
        logic [65:0] mag;
        logic [65:0] sum;
        mag = v[65] ? 66'd0 - v : v;
        sum = mag + (66'd1 << 29);
        return sum[65:30];
    endfunction

    function automatic logic [31:0] up_of(input logic signed [65:0] v);
        logic [35:0] r;
        logic [31:0] c;
        r = rnd30(v);
        c = (r > {4'd0, lamv_pkg::AXIS_ONE}) ? lamv_pkg::AXIS_ONE : r[31:0];
        return v[65] ? 32'd0 - c : c;
    endfunction

    // Offset is -dot, so a negative dot gives a positive result.
    function automatic logic [31:0] off_of(input logic signed [65:0] v);
        logic [35:0] r;
        logic [31:0] o;
        r = rnd30(v);
        if (v[65]) begin
            o = (r > 36'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
        end else begin
            o = (r > 36'h0_8000_0000) ? 32'h8000_0000 : 32'd0 - r[31:0];
        end
        return o;
    endfunction

    always_comb begin
        w_opa       = r_upv;
        w_opb       = r_f;
        w_ia        = (r_t == 2'd0) ? lamv_pkg::next3(r_k) : lamv_pkg::prev3(r_k);
        w_ib        = (r_t == 2'd0) ? lamv_pkg::prev3(r_k) : lamv_pkg::next3(r_k);
        w_minus     = (r_t == 2'd1);
        w_last_term = (r_t == 2'd1);
        if (r_state == lamv_pkg::B_CR2) begin
            w_opa = r_f;
            w_opb = r_s;
        end else if (r_state == lamv_pkg::B_DOT) begin
            unique case (r_k)
                lamv_pkg::ROW_SIDE: w_opa = r_s;
                lamv_pkg::ROW_UP:   w_opa = r_u;
                default:            w_opa = r_f;
            endcase
            w_opb       = r_eye;
            w_ia        = r_t;
            w_ib        = r_t;
            w_minus     = 1'b0;
            w_last_term = (r_t == 2'd2);
        end
        w_term  = {{2{r_prod[63]}}, r_prod};
        w_acc_n = ((r_t == 2'd0) ? 66'sd0 : r_acc) + (w_minus ? -w_term : w_term);
    end

    assign w_load   = (r_state == lamv_pkg::B_EMIT) && (!r_ovld || !i_stall);
    assign o_pop    = (r_state == lamv_pkg::B_IDLE) && !i_empty;
    assign o_nstart = (r_state == lamv_pkg::B_NF_GO) || (r_state == lamv_pkg::B_NS_GO);

    always_comb begin
        if (r_state == lamv_pkg::B_NS_GO) begin
            o_nvec = r_c;
        end else begin
            for (int i = 0; i < 3; i++) o_nvec[i] = {{31{r_dif[i][32]}}, r_dif[i]};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lamv_pkg::B_IDLE:    if (!i_empty) n_state = lamv_pkg::B_NF_GO;
            lamv_pkg::B_NF_GO:   n_state = lamv_pkg::B_NF_WAIT;
            lamv_pkg::B_NF_WAIT: if (i_nrsp.done) n_state = lamv_pkg::B_CR1;
            lamv_pkg::B_CR1: begin
                if (r_ph && w_last_term && r_k == 2'd2) n_state = lamv_pkg::B_NS_GO;
            end
            lamv_pkg::B_NS_GO:   n_state = lamv_pkg::B_NS_WAIT;
            lamv_pkg::B_NS_WAIT: if (i_nrsp.done) n_state = lamv_pkg::B_CR2;
            lamv_pkg::B_CR2: begin
                if (r_ph && w_last_term && r_k == 2'd2) n_state = lamv_pkg::B_DOT;
            end
            lamv_pkg::B_DOT: begin
                if (r_ph && w_last_term && r_k == 2'd2) n_state = lamv_pkg::B_EMIT;
            end
            lamv_pkg::B_EMIT:    if (w_load && r_k == 2'd2) n_state = lamv_pkg::B_IDLE;
            default:             n_state = lamv_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lamv_pkg::B_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            lamv_pkg::B_IDLE: begin
                r_eye <= i_item.eye;
                r_upv <= i_item.upv;
                r_dif <= i_item.dif;
            end
            lamv_pkg::B_NF_WAIT, lamv_pkg::B_NS_WAIT: begin
                r_k  <= 2'd0;
                r_t  <= 2'd0;
                r_ph <= 1'b0;
                if (i_nrsp.done) begin
                    if (r_state == lamv_pkg::B_NF_WAIT) begin
                        r_f   <= i_naxis;
                        r_okf <= i_nrsp.ok;
                    end else begin
                        r_s   <= i_naxis;
                        r_oks <= i_nrsp.ok;
                    end
                end
            end
            lamv_pkg::B_CR1, lamv_pkg::B_CR2, lamv_pkg::B_DOT: begin
                r_ph <= !r_ph;
                if (!r_ph) begin
                    r_prod <= $signed(w_opa[w_ia]) * $signed(w_opb[w_ib]);
                end else begin
                    r_acc <= w_acc_n;
                    if (w_last_term) begin
                        r_t <= 2'd0;
                        r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                        unique case (r_state)
                            lamv_pkg::B_CR1: r_c[r_k]   <= w_acc_n[63:0];
                            lamv_pkg::B_CR2: r_u[r_k]   <= up_of(w_acc_n);
                            default:         r_off[r_k] <= off_of(w_acc_n);
                        endcase
                    end else begin
                        r_t <= r_t + 2'd1;
                    end
                end
            end
            lamv_pkg::B_EMIT: begin
                if (w_load) r_k <= r_k + 2'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_orow <= r_k;
            unique case (r_k)
                lamv_pkg::ROW_SIDE: r_oaxis <= r_s;
                lamv_pkg::ROW_UP:   r_oaxis <= r_u;
                default:            r_oaxis <= r_f;
            endcase
            r_ooff <= r_off[r_k];
            r_odeg <= !(r_okf && r_oks);
        end
    end

    assign o_valid      = r_ovld;
    assign o_row_index  = r_orow;
    assign o_axis       = r_oaxis;
    assign o_offset     = r_ooff;
    assign o_degenerate = r_odeg;
    assign o_last_row   = (r_orow == lamv_pkg::ROW_FWD);

endmodule
`default_nettype wire

// File: rtl/look_at_view_matrix_unit.sv
// Top level of the left-handed look-at view matrix unit.
`default_nettype none
// Builds a left-handed view matrix from an eye point, a target point and a
// reference up vector, all signed Q16.16. Each request transfer yields three
// result transfers in order: row 0 side axis, row 1 recomputed up axis, row 2
// forward axis. Every row has a unit axis in Q2.30 (components within +/-2^30),
// the negated dot of that axis with the eye rounded and saturated to Q16.16,
// a degenerate flag (same on all three rows, set when target equals eye or up
// is zero or parallel to the view direction; side and up axes and offsets are
// then zero) and last_row on row 2. A front stage forms (target - eye) and
// feeds a two-entry queue, so new requests are taken while the sequencer is
// busy and while a finished row waits on the output register. Throughput is
// set by the shared normalizer, used twice per request for a range shift, the
// sum of squares, the bit-serial square root, the bit-serial divides and a
// done state, and by the shared multiplier steps for the cross products and
// the offsets, the row emits and the sequencer handoff. The sequencer pops the
// next request only after the last row of the previous one is loaded into the
// output register, so output stalls also hold back requests. When the view
// direction is zero, both normalizer runs skip the sum of squares, the square
// root and the divides.
module look_at_view_matrix_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_eye_x,
    input  wire logic [31:0] i_eye_y,
    input  wire logic [31:0] i_eye_z,
    input  wire logic [31:0] i_target_x,
    input  wire logic [31:0] i_target_y,
    input  wire logic [31:0] i_target_z,
    input  wire logic [31:0] i_upward_x,
    input  wire logic [31:0] i_upward_y,
    input  wire logic [31:0] i_upward_z,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_row_index,
    output logic [31:0]      o_axis_x,
    output logic [31:0]      o_axis_y,
    output logic [31:0]      o_axis_z,
    output logic [31:0]      o_offset,
    output logic             o_degenerate,
    output logic             o_last_row
);

    lamv_pkg::t_vec32    w_eye, w_tgt, w_upv;
    lamv_pkg::t_item     w_fitem, w_qitem;
    logic                w_push, w_full, w_pop, w_empty;
    logic                w_nstart;
    lamv_pkg::t_vec64    w_nvec;
    lamv_pkg::t_norm_rsp w_nrsp;
    lamv_pkg::t_vec32    w_naxis;
    lamv_pkg::t_vec32    w_oaxis;

    assign w_eye = {i_eye_z, i_eye_y, i_eye_x};
    assign w_tgt = {i_target_z, i_target_y, i_target_x};
    assign w_upv = {i_upward_z, i_upward_y, i_upward_x};

    // Request side: register the transfer and form the view direction.
    lamv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_item  (w_fitem),
        .i_eye   (w_eye),
        .i_tgt   (w_tgt),
        .i_upv   (w_upv)
    );

    // Decouples the front stage from the long-running sequencer.
    lamv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_qitem)
    );

    // Shared normalizer: forward first, then the side vector.
    lamv_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_nstart),
        .i_vec   (w_nvec),
        .o_rsp   (w_nrsp),
        .o_axis  (w_naxis)
    );

    lamv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_item       (w_qitem),
        .o_pop        (w_pop),
        .o_nstart     (w_nstart),
        .o_nvec       (w_nvec),
        .i_nrsp       (w_nrsp),
        .i_naxis      (w_naxis),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_row_index  (o_row_index),
        .o_axis       (w_oaxis),
        .o_offset     (o_offset),
        .o_degenerate (o_degenerate),
        .o_last_row   (o_last_row)
    );

    assign o_axis_x = w_oaxis[0];
    assign o_axis_y = w_oaxis[1];
    assign o_axis_z = w_oaxis[2];

    // Only the forward row closes a matrix.
    a_last_is_fwd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_row == (o_row_index == lamv_pkg::ROW_FWD)))
        else $error("last_row flag does not match forward row");

    // Unit axes never exceed one in Q2.30.
    a_axis_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_axis_x) <= 32'sh4000_0000 &&
                     $signed(o_axis_x) >= -32'sh4000_0000 &&
                     $signed(o_axis_y) <= 32'sh4000_0000 &&
                     $signed(o_axis_y) >= -32'sh4000_0000 &&
                     $signed(o_axis_z) <= 32'sh4000_0000 &&
                     $signed(o_axis_z) >= -32'sh4000_0000))
        else $error("axis component out of unit range");

    // A degenerate matrix has zero side and up rows.
    a_degen_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate && o_row_index != lamv_pkg::ROW_FWD) |->
        (o_axis_x == 32'd0 && o_axis_y == 32'd0 && o_axis_z == 32'd0 &&
         o_offset == 32'd0))
        else $error("degenerate row carries nonzero data");

endmodule
`default_nettype wire

// File: tb/lamv_checker.sv
// Checker for the look-at view matrix unit: predicts rows and compares result transfers.
`timescale 1ns / 1ps
module lamv_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        o_stall,
    input  wire logic [31:0] i_eye_x,
    input  wire logic [31:0] i_eye_y,
    input  wire logic [31:0] i_eye_z,
    input  wire logic [31:0] i_target_x,
    input  wire logic [31:0] i_target_y,
    input  wire logic [31:0] i_target_z,
    input  wire logic [31:0] i_upward_x,
    input  wire logic [31:0] i_upward_y,
    input  wire logic [31:0] i_upward_z,
    input  wire logic        o_valid,
    input  wire logic        i_stall,
    input  wire logic [1:0]  o_row_index,
    input  wire logic [31:0] o_axis_x,
    input  wire logic [31:0] o_axis_y,
    input  wire logic [31:0] o_axis_z,
    input  wire logic [31:0] o_offset,
    input  wire logic        o_degenerate,
    input  wire logic        o_last_row,
    output int               fail_count,
    output int               rows_pending
);

    typedef struct packed {
        logic [1:0]  row;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic [31:0] ofs;
        logic        degen;
        logic        last;
    } t_row;

    typedef logic signed [63:0] t_s64;

    t_row expected_rows[$];

    function automatic logic [63:0] mag64(input t_s64 v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= root + bitv) begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Unit vector in Q2.30; returns 0 when the length is zero.
    function automatic logic unit_vec(input t_s64 v[3], output t_s64 r[3]);
        logic [63:0] m[3];
        logic [63:0] mx, sum, len, q;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag64(v[i]);
            r[i] = 0;
        end
        if ((m[0] | m[1] | m[2]) == 0) return 1'b0;
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        while (mx >= (64'd1 << 31)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 30) + (len >> 1)) / len;
            if (q > 64'd1 << 30) q = 64'd1 << 30;
            r[i] = v[i] < 0 ? -t_s64'(q) : t_s64'(q);
        end
        return 1'b1;
    endfunction

    function automatic void cross_prod(input t_s64 a[3], input t_s64 b[3],
                                       output t_s64 r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic t_s64 round_q30(input t_s64 v);
        logic [63:0] m;
        m = (mag64(v) + (64'd1 << 29)) >> 30;
        return v < 0 ? -t_s64'(m) : t_s64'(m);
    endfunction

    function automatic logic [31:0] eye_offset(input t_s64 ax[3], input t_s64 eye[3]);
        t_s64 r;
        r = round_q30(-(ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2]));
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    task automatic predict_view_rows(input logic [31:0] raw[9]);
        t_s64 eye[3], tgt[3], upv[3], dir[3], fwd[3], crs[3], side[3], up2[3];
        t_s64 axes[3][3];
        logic ok_f, ok_s, degen;
        t_row r;
        for (int i = 0; i < 3; i++) begin
            eye[i] = $signed(raw[i]);
            tgt[i] = $signed(raw[3 + i]);
            upv[i] = $signed(raw[6 + i]);
            dir[i] = tgt[i] - eye[i];
        end
        ok_f = unit_vec(dir, fwd);
        cross_prod(upv, fwd, crs);
        ok_s = unit_vec(crs, side);
        cross_prod(fwd, side, up2);
        for (int i = 0; i < 3; i++) begin
            up2[i] = round_q30(up2[i]);
            if (up2[i] > 64'sd1073741824) up2[i] = 64'sd1073741824;
            if (up2[i] < -64'sd1073741824) up2[i] = -64'sd1073741824;
        end
        degen = !(ok_f && ok_s);
        axes[0] = side;
        axes[1] = up2;
        axes[2] = fwd;
        for (int k = 0; k < 3; k++) begin
            r.row = (k == 0) ? lamv_pkg::ROW_SIDE :
                    (k == 1) ? lamv_pkg::ROW_UP : lamv_pkg::ROW_FWD;
            r.ax = axes[k][0][31:0];
            r.ay = axes[k][1][31:0];
            r.az = axes[k][2][31:0];
            r.ofs = eye_offset(axes[k], eye);
            r.degen = degen;
            r.last = (k == 2);
            expected_rows.push_back(r);
        end
    endtask

    initial fail_count = 0;
    initial rows_pending = 0;

    always @(posedge i_clk) begin
        t_row got, want;
        logic [31:0] raw[9];
        if (i_rst_n && i_valid && !o_stall) begin
            raw = '{i_eye_x, i_eye_y, i_eye_z, i_target_x, i_target_y, i_target_z,
                    i_upward_x, i_upward_y, i_upward_z};
            predict_view_rows(raw);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_row_index, o_axis_x, o_axis_y, o_axis_z, o_offset,
                    o_degenerate, o_last_row};
            if (expected_rows.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: unexpected row transfer %h", got);
            end else begin
                want = expected_rows.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("ERROR: row mismatch exp row=%0d ax=%h ay=%h az=%h ofs=%h dg=%b lr=%b",
                                 want.row, want.ax, want.ay, want.az, want.ofs,
                                 want.degen, want.last);
                        $display("       got row=%0d ax=%h ay=%h az=%h ofs=%h dg=%b lr=%b",
                                 got.row, got.ax, got.ay, got.az, got.ofs,
                                 got.degen, got.last);
                    end
                end
            end
        end
        rows_pending <= expected_rows.size();
    end
endmodule

// File: tb/tb.sv
// Top of the look-at view matrix testbench: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb;

    localparam int RANDOM_REQUESTS = 500;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 4000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_eye_x = '0, i_eye_y = '0, i_eye_z = '0;
    logic [31:0] i_target_x = '0, i_target_y = '0, i_target_z = '0;
    logic [31:0] i_upward_x = '0, i_upward_y = '0, i_upward_z = '0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    logic [1:0]  o_row_index;
    logic [31:0] o_axis_x, o_axis_y, o_axis_z, o_offset;
    logic        o_degenerate, o_last_row;
    int          fail_count, rows_pending;
    int          cycle_count = 0;
    logic        hold_start = 1'b0;   // kicks off the long receiver hold-off
    logic        hold_output = 1'b0;  // long receiver hold-off in progress

    always #4 i_clk = ~i_clk;

    look_at_view_matrix_unit dut (.*);
    lamv_checker checker_i (.*);

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("look_at_view_matrix_unit verification failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Long hold-off, timed here so the sender keeps offering while the block fills.
    initial begin
        @(posedge hold_start);
        hold_output <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_output <= 1'b0;
    end

    // Receiver stall: random stalls, and once a long hold while requests pile up.
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_output) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 30);
        end
    end

    task automatic send_request(input logic [31:0] v[9]);
        i_eye_x <= v[0]; i_eye_y <= v[1]; i_eye_z <= v[2];
        i_target_x <= v[3]; i_target_y <= v[4]; i_target_z <= v[5];
        i_upward_x <= v[6]; i_upward_y <= v[7]; i_upward_z <= v[8];
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic idle_between(input int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Coordinate with a bias toward small, edge and full-range values.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 32'h1fff_ffff)) - 32'sh1000_0000);
            3: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
            default: return 32'($signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000);
        endcase
    endfunction

    initial begin
        logic [31:0] v[9];
        logic [31:0] mx, mn;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ordinary camera, degenerate cases and field extremes.
        send_request('{0, 0, 0, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 0});
        send_request('{32'h0003_0000, 32'h0002_0000, mn, 0, 0, 0, 0, 32'h0001_0000, 0});
        send_request('{32'h0001_0000, 2, 3, 32'h0001_0000, 2, 3, 0, 32'h0001_0000, 0});
        send_request('{0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 0});
        send_request('{0, 0, 0, 0, 32'h0005_0000, 0, 0, 32'h0002_0000, 0});
        send_request('{0, 0, 0, 0, 32'hfffb_0000, 0, 0, 32'h0002_0000, 0});
        send_request('{mn, mn, mn, mx, mx, mx, mx, mn, mx});
        send_request('{mx, mx, mx, mn, mn, mn, mn, mx, 1});
        send_request('{mx, mn, mx, mn, mx, mn, 1, 0, 0});
        send_request('{0, 0, 0, 1, 0, 0, 0, 1, 0});
        send_request('{mx, mx, mx, mx, mx, 32'h7fff_fffe, mx, mx, mx});
        send_request('{mn, 0, mx, 0, mn, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
        send_request('{mx, mx, mx, 0, 0, 0, 1, 1, 1});
        send_request('{32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f, 32'hf0f0_f0f0,
                       32'h5555_5555, 32'haaaa_aaaa, mx, mn, 0});
        i_valid <= 1'b0;

        // Sender pause until everything has drained.
        while (rows_pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            foreach (v[i]) v[i] = rand_coord();
            case ($urandom_range(0, 19))
                0: for (int i = 0; i < 3; i++) v[3 + i] = v[i];          // target on eye
                1: for (int i = 0; i < 3; i++) v[6 + i] = 0;             // no up vector
                2: for (int i = 0; i < 3; i++) v[6 + i] = v[3 + i] - v[i]; // up along view
                default: ;
            endcase
            if (n == 100) hold_start <= 1'b1;
            send_request(v);
            idle_between(gap_len());
        end
        i_valid <= 1'b0;

        while (rows_pending != 0) @(posedge i_clk);
        repeat (700) @(posedge i_clk);
        if (fail_count == 0)
            $display("look_at_view_matrix_unit verification clean");
        else
            $display("look_at_view_matrix_unit verification failed");
        $finish;
    end
endmodule
